>>> hw/rtl/rpap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpap_pkg
// shared types and constants of the radius packet attribute parser
// ----------------------------------------------------------------------------
package rpap_pkg;

    localparam int POS_W           = 13;
    localparam int OFF_W           = 12;
    localparam int HDR_BYTES       = 20;
    localparam int VSA_TYPE        = 26;
    localparam int VENDOR_ID_BYTES = 4;
    localparam int CODE_LOW_MAX    = 5;
    localparam int CODE_HIGH_MIN   = 11;
    localparam int CODE_MAX        = 13;
    localparam int MIN_ATTR_LEN    = 2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_WALK,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        EV_ACCEPT = 3'd0,
        EV_REJECT = 3'd1,
        EV_ATTR   = 3'd2,
        EV_SUB    = 3'd3,
        EV_END    = 3'd4
    } t_kind;

    // one queue entry: first result of a byte, plus a trailing packet end
    typedef struct packed {
        t_kind              kind;
        logic               has_end;
        logic [7:0]         code;
        logic [7:0]         ident;
        logic [15:0]        len;
        logic [7:0]         attr_type;
        logic [OFF_W-1:0]   value_offset;
        logic [7:0]         value_length;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> hw/rtl/rpap_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpap_front
// per-byte header check and attribute walk, at most one queue entry per byte
// ----------------------------------------------------------------------------
module rpap_front
    import rpap_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_bsz,
    input  logic        i_first,
    input  logic        i_fin,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_BYTES);

    t_phase             r_phase,  n_phase,  e_phase;
    logic [POS_W-1:0]   r_pos,    n_pos,    e_pos;
    logic [7:0]         r_code,   n_code,   e_code;
    logic [7:0]         r_ident,  n_ident,  e_ident;
    logic [15:0]        r_len,    n_len,    e_len;
    logic [7:0]         r_otype,  n_otype,  e_otype;
    logic [POS_W-1:0]   r_oend,   n_oend,   e_oend;
    logic [POS_W-1:0]   r_sreg,   n_sreg,   e_sreg;
    logic [7:0]         r_stype,  n_stype,  e_stype;
    logic [POS_W-1:0]   r_send,   n_send,   e_send;
    logic               r_ostop,  n_ostop,  e_ostop;
    logic               r_sstop,  n_sstop,  e_sstop;

    logic               bad;
    logic               p_acc, p_rej, p_attr, p_sub, p_end;
    logic [15:0]        room;
    logic [POS_W-1:0]   sroom;
    logic [POS_W:0]     next_end;
    logic [7:0]         rtype;

    // first byte restarts the packet before the byte is used
    always_comb begin
        e_phase = i_first ? PH_HEADER : r_phase;
        e_pos   = i_first ? '0 : r_pos;
        e_code  = i_first ? '0 : r_code;
        e_ident = i_first ? '0 : r_ident;
        e_len   = i_first ? '0 : r_len;
        e_otype = i_first ? '0 : r_otype;
        e_oend  = i_first ? '0 : r_oend;
        e_sreg  = i_first ? '0 : r_sreg;
        e_stype = i_first ? '0 : r_stype;
        e_send  = i_first ? '0 : r_send;
        e_ostop = i_first ? 1'b0 : r_ostop;
        e_sstop = i_first ? 1'b0 : r_sstop;
    end

    always_comb begin
        n_phase = e_phase;  n_pos   = e_pos;   n_code  = e_code;
        n_ident = e_ident;  n_len   = e_len;   n_otype = e_otype;
        n_oend  = e_oend;   n_sreg  = e_sreg;  n_stype = e_stype;
        n_send  = e_send;   n_ostop = e_ostop; n_sstop = e_sstop;
        bad = 1'b0;
        p_acc = 1'b0; p_rej = 1'b0; p_attr = 1'b0; p_sub = 1'b0; p_end = 1'b0;
        room = '0;
        sroom = '0;
        next_end = '0;
        rtype = '0;
        case (e_phase)
            PH_HEADER: begin
                case (e_pos)
                    POS_W'(0): begin
                        n_code = i_data;
                        if (i_bsz < 16'(HDR_BYTES) || i_bsz > MAX_LEN ||
                            i_data > 8'(CODE_MAX) ||
                            (i_data > 8'(CODE_LOW_MAX) && i_data < 8'(CODE_HIGH_MIN))) begin
                            bad = 1'b1;
                        end
                    end
                    POS_W'(1): n_ident = i_data;
                    POS_W'(2): n_len = {i_data, 8'h00};
                    POS_W'(3): begin
                        n_len = {e_len[15:8], i_data};
                        if (n_len < 16'(HDR_BYTES) || n_len > MAX_LEN || i_bsz < n_len) begin
                            bad = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!bad && e_pos == POS_W'(HDR_BYTES - 1)) begin
                    p_acc   = 1'b1;
                    n_oend  = POS_W'(HDR_BYTES);
                    n_ostop = 1'b0;
                    n_sstop = 1'b1;
                    n_sreg  = '0;
                    if (n_len <= 16'(HDR_BYTES) || i_fin) begin
                        p_end   = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_WALK;
                    end
                end else if (bad || i_fin) begin
                    p_rej   = 1'b1;
                    n_phase = PH_DONE;
                end
                n_pos = e_pos + 1'b1;
            end
            PH_WALK: begin
                room  = e_len - 16'(e_oend);
                sroom = e_sreg - e_send;
                next_end = {1'b0, e_oend} + (POS_W+1)'(i_data);
                if (!e_ostop && e_pos == e_oend) begin
                    n_otype = i_data;
                    if (e_len - 16'(e_pos) < 16'(MIN_ATTR_LEN)) begin
                        n_ostop = 1'b1;
                    end
                end else if (!e_ostop && {1'b0, e_pos} == {1'b0, e_oend} + 1'b1) begin
                    if (i_data < 8'(MIN_ATTR_LEN) || 16'(i_data) > room) begin
                        n_ostop = 1'b1;
                    end else begin
                        p_attr = 1'b1;
                        rtype  = e_otype;
                        if (e_otype == 8'(VSA_TYPE) &&
                            i_data > 8'(MIN_ATTR_LEN + VENDOR_ID_BYTES)) begin
                            n_send  = e_oend + POS_W'(MIN_ATTR_LEN + VENDOR_ID_BYTES);
                            n_sreg  = next_end[POS_W-1:0];
                            n_sstop = 1'b0;
                        end else begin
                            n_sstop = 1'b1;
                        end
                        n_oend = next_end[POS_W-1:0];
                    end
                end else if (!e_sstop && e_pos < e_sreg) begin
                    if (e_pos == e_send) begin
                        n_stype = i_data;
                        if (e_sreg - e_pos < POS_W'(MIN_ATTR_LEN)) begin
                            n_sstop = 1'b1;
                        end
                    end else if ({1'b0, e_pos} == {1'b0, e_send} + 1'b1) begin
                        if (i_data < 8'(MIN_ATTR_LEN) || POS_W'(i_data) > sroom) begin
                            n_sstop = 1'b1;
                        end else begin
                            p_sub  = 1'b1;
                            rtype  = e_stype;
                            n_send = e_send + POS_W'(i_data);
                        end
                    end
                end
                if (16'(e_pos) + 16'd1 >= e_len || i_fin) begin
                    p_end   = 1'b1;
                    n_phase = PH_DONE;
                end
                n_pos = e_pos + 1'b1;
            end
            default: ;
        endcase
    end

    // the first result of the byte goes in the entry, a packet end rides along
    always_comb begin
        o_push = i_accept && (p_acc || p_rej || p_attr || p_sub || p_end);
        o_entry.code  = n_code;
        o_entry.ident = n_ident;
        o_entry.len   = n_len;
        o_entry.attr_type    = rtype;
        o_entry.value_offset = (p_attr || p_sub) ? OFF_W'(e_pos + 1'b1) : '0;
        o_entry.value_length = (p_attr || p_sub) ? i_data - 8'(MIN_ATTR_LEN) : '0;
        o_entry.has_end = p_end && (p_acc || p_attr || p_sub);
        if (p_acc) begin
            o_entry.kind = EV_ACCEPT;
        end else if (p_rej) begin
            o_entry.kind = EV_REJECT;
        end else if (p_attr) begin
            o_entry.kind = EV_ATTR;
        end else if (p_sub) begin
            o_entry.kind = EV_SUB;
        end else begin
            o_entry.kind = EV_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;  r_code  <= '0;  r_ident <= '0;  r_len   <= '0;
            r_otype <= '0;  r_oend  <= '0;  r_sreg  <= '0;  r_stype <= '0;
            r_send  <= '0;  r_ostop <= 1'b0; r_sstop <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;   r_code  <= n_code;  r_ident <= n_ident;
            r_len   <= n_len;   r_otype <= n_otype; r_oend  <= n_oend;
            r_sreg  <= n_sreg;  r_stype <= n_stype; r_send  <= n_send;
            r_ostop <= n_ostop; r_sstop <= n_sstop;
        end
    end

endmodule

>>> hw/rtl/rpap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpap_queue
// small fifo of result entries between the parser and the output stage
// ----------------------------------------------------------------------------
module rpap_queue
    import rpap_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output t_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push || i_pop)
        else $error("entry pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("entry popped from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue fill count lost a push");

endmodule

>>> hw/rtl/rpap_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpap_back
// output stage: turns queue entries into one or two result beats
// ----------------------------------------------------------------------------
module rpap_back
    import rpap_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_entry i_head,
    input  t_qstat i_stat,
    output logic   o_pop,
    input  logic   i_ready,
    output logic   o_valid,
    output t_entry o_beat,
    output logic   o_last
);

    logic   r_valid, n_valid;
    t_entry r_beat,  n_beat;
    logic   r_last,  n_last;
    logic   r_pend,  n_pend;
    t_entry r_hold,  n_hold;
    logic   load;

    always_comb begin
        load    = !r_valid || i_ready;
        n_valid = r_valid;
        n_beat  = r_beat;
        n_last  = r_last;
        n_pend  = r_pend;
        n_hold  = r_hold;
        o_pop   = 1'b0;
        if (load) begin
            if (r_pend) begin
                // trailing packet end of the previous entry
                n_valid = 1'b1;
                n_beat  = r_hold;
                n_beat.kind = EV_END;
                n_beat.has_end = 1'b0;
                n_beat.attr_type = '0;
                n_beat.value_offset = '0;
                n_beat.value_length = '0;
                n_last  = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_stat.empty) begin
                n_valid = 1'b1;
                n_beat  = i_head;
                n_last  = !i_head.has_end;
                n_pend  = i_head.has_end;
                n_hold  = i_head;
                o_pop   = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
        r_last <= n_last;
        r_hold <= n_hold;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
    assign o_last  = r_last;

    a_pend_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && !r_last)
        else $error("pending packet end without its leading beat");

    a_pend_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_pop)
        else $error("queue popped while a packet end is pending");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_beat.kind == EV_END) |-> r_last)
        else $error("packet end beat not marked last");

endmodule

>>> hw/rtl/radius_packet_attribute_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_packet_attribute_parser_unit
// byte-serial radius header check and attribute / vendor sub-attribute walk
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | tlast
//  s_axis  | in  | data_byte, buffer_size        | first_byte  | final_byte
//  m_axis  | out | code, ident, length, type,    | event_kind  | last_of_run
//          |     | value_offset, value_length    |             |
//
//  one byte beat is taken per cycle while the queue is not full; the parser
//  updates its walk state on the accepting edge and drops zero or one entry
//  into a short queue; an entry carrying both a result and a packet end
//  leaves as two output beats, the result first and the packet end after it,
//  so the output side can fall behind the input; the queue absorbs the difference
//  s_axis_tready falls only while the queue is full
//  synchronous active-low reset clears the walk state, the queue and the
//  output register; the first beat after reset starts a packet
// ----------------------------------------------------------------------------
module radius_packet_attribute_parser_unit
    import rpap_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 4096,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte[7:0], buffer_size[23:8]
    input  logic        s_axis_tuser,  // first_byte
    input  logic        s_axis_tlast,  // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // packet_code[7:0], packet_identifier[15:8], packet_length[31:16],
    // attribute_type[39:32], value_offset[51:40], value_length[59:52], zero pad
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,  // event_kind
    output logic        m_axis_tlast   // last_of_run
);

    logic   accept;
    logic   push;
    logic   pop;
    t_entry entry;
    t_entry head;
    t_qstat qstat;
    t_entry beat;

    // accept whenever the queue has room for this beat's entry
    assign s_axis_tready = !qstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rpap_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (s_axis_tdata[7:0]),
        .i_bsz    (s_axis_tdata[23:8]),
        .i_first  (s_axis_tuser),
        .i_fin    (s_axis_tlast),
        .o_push   (push),
        .o_entry  (entry)
    );

    rpap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    rpap_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (qstat),
        .o_pop   (pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_beat  (beat),
        .o_last  (m_axis_tlast)
    );

    // pack the result beat, lowest field first
    assign m_axis_tdata = {4'h0, beat.value_length, beat.value_offset, beat.attr_type,
                           beat.len, beat.ident, beat.code};
    assign m_axis_tuser = beat.kind;

endmodule
